/* design/sfl_pkg.sv */
package sfl_pkg;

	// Heap geometry
	localparam int HeapBytes  = 65536;
	localparam int ChunkBytes = 512;
	localparam int NumClasses = 11;
	localparam int HeapLimit  = ((HeapBytes < 65536) ? HeapBytes : 65536) / 8 * 8;
	localparam int NWords     = HeapLimit / 4;
	localparam int WordAw     = $clog2(NWords);
	localparam int TableArea  = 'h58;
	localparam int FirstBp    = TableArea + 16;
	localparam int MinBlock   = 24;
	localparam int WalkLimit  = HeapLimit / 8;

	// Widths
	localparam int ClsW   = $clog2(NumClasses);
	localparam int StepsW = $clog2(WalkLimit + 1);
	localparam int EndW   = $clog2(HeapLimit + 1);
	localparam int AsW    = 17;
	localparam int GsW    = AsW + 1;
	localparam int AddrW  = 16;
	localparam int DataW  = 32;
	localparam int StW    = 6;

	// Sequencer steps
	localparam logic [StW-1:0] S_CLR  = 6'd0;
	localparam logic [StW-1:0] S_I0   = 6'd1;
	localparam logic [StW-1:0] S_I1   = 6'd2;
	localparam logic [StW-1:0] S_I2   = 6'd3;
	localparam logic [StW-1:0] S_IDLE = 6'd4;
	localparam logic [StW-1:0] S_DSP  = 6'd5;
	localparam logic [StW-1:0] S_DONE = 6'd6;
	localparam logic [StW-1:0] S_FR0  = 6'd7;
	localparam logic [StW-1:0] S_FR1  = 6'd8;
	localparam logic [StW-1:0] S_FR2  = 6'd9;
	localparam logic [StW-1:0] S_F1   = 6'd10;
	localparam logic [StW-1:0] S_F2   = 6'd11;
	localparam logic [StW-1:0] S_F3   = 6'd12;
	localparam logic [StW-1:0] S_F4   = 6'd13;
	localparam logic [StW-1:0] S_G0   = 6'd14;
	localparam logic [StW-1:0] S_G1   = 6'd15;
	localparam logic [StW-1:0] S_G2   = 6'd16;
	localparam logic [StW-1:0] S_GR   = 6'd17;
	localparam logic [StW-1:0] S_M0   = 6'd18;
	localparam logic [StW-1:0] S_M1   = 6'd19;
	localparam logic [StW-1:0] S_M2   = 6'd20;
	localparam logic [StW-1:0] S_M3   = 6'd21;
	localparam logic [StW-1:0] S_M4   = 6'd22;
	localparam logic [StW-1:0] S_M5   = 6'd23;
	localparam logic [StW-1:0] S_M6   = 6'd24;
	localparam logic [StW-1:0] S_MA1  = 6'd25;
	localparam logic [StW-1:0] S_MA2  = 6'd26;
	localparam logic [StW-1:0] S_MB1  = 6'd27;
	localparam logic [StW-1:0] S_MB2  = 6'd28;
	localparam logic [StW-1:0] S_MC1  = 6'd29;
	localparam logic [StW-1:0] S_MC2  = 6'd30;
	localparam logic [StW-1:0] S_MC3  = 6'd31;
	localparam logic [StW-1:0] S_P0   = 6'd32;
	localparam logic [StW-1:0] S_P1   = 6'd33;
	localparam logic [StW-1:0] S_PS0  = 6'd34;
	localparam logic [StW-1:0] S_PS1  = 6'd35;
	localparam logic [StW-1:0] S_PS2  = 6'd36;
	localparam logic [StW-1:0] S_PS3  = 6'd37;
	localparam logic [StW-1:0] S_PN0  = 6'd38;
	localparam logic [StW-1:0] S_PN1  = 6'd39;
	localparam logic [StW-1:0] S_RM0  = 6'd40;
	localparam logic [StW-1:0] S_RM1  = 6'd41;
	localparam logic [StW-1:0] S_RM2  = 6'd42;
	localparam logic [StW-1:0] S_RM3  = 6'd43;
	localparam logic [StW-1:0] S_RM4  = 6'd44;
	localparam logic [StW-1:0] S_RM5  = 6'd45;
	localparam logic [StW-1:0] S_IN0  = 6'd46;
	localparam logic [StW-1:0] S_IN1  = 6'd47;
	localparam logic [StW-1:0] S_IN2  = 6'd48;

	// Controller to datapath
	typedef struct packed {
		logic [StW-1:0] step;
		logic           accept;
		logic           load_out;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic op;
		logic req_zero;
		logic free_bad;
		logic rd_alloc;
		logic clr_last;
		logic list_end;
		logic last_cls;
		logic fit;
		logic gfail;
		logic bp_zero;
		logic pa;
		logic na;
		logic split;
	} sts_t;

	// Size field of a boundary tag
	function automatic logic [DataW-1:0] tsize(input logic [DataW-1:0] v);
		return {v[DataW-1:3], 3'b000};
	endfunction

	// Power-of-two size class, last class open ended
	function automatic logic [ClsW-1:0] class_of(input logic [DataW-1:0] size);
		logic [ClsW-1:0] c;
		c = '0;
		for (int i = 0; i < NumClasses - 1; i++) begin
			if (size >= (DataW'(32) << i))
				c = ClsW'(i + 1);
		end
		return c;
	endfunction

endpackage

/* design/sfl_ram.sv */
module sfl_ram #(
	parameter int Width = 32,
	parameter int Depth = 16384
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] addr,
	input  logic [Width-1:0]         wdata,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem_q [Depth];
	logic [Width-1:0] rdata_q;

	// Single port, registered read
	always_ff @(posedge clk) begin
		if (we)
			mem_q[addr] <= wdata;
		else
			rdata_q <= mem_q[addr];
	end

	assign rdata = rdata_q;

endmodule

/* design/sfl_dp.sv */
module sfl_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  sfl_pkg::cmd_t                cmd,
	output sfl_pkg::sts_t                sts,
	input  logic                         op,
	input  logic [15:0]                  request_size,
	input  logic [15:0]                  block_addr,
	output logic [15:0]                  result_addr,
	output logic                         ok
);

	localparam int DW = sfl_pkg::DataW;
	localparam int AW = sfl_pkg::AddrW;

	// Request registers
	logic                        op_q;
	logic [15:0]                 req_q;
	logic [15:0]                 addr_q;
	logic [sfl_pkg::AsW-1:0]     asize_q;
	logic [sfl_pkg::AsW-1:0]     gext_q;
	logic [sfl_pkg::GsW-1:0]     gs_q;

	// Working registers
	logic [DW-1:0]               bp_q, pb_q, size_q, ps_q, ns_q, csize_q;
	logic [AW-1:0]               nb_q, cur_q, lx_q, lp_q, ln_q;
	logic [sfl_pkg::ClsW-1:0]    cls_q, lc_q, pc_q;
	logic [sfl_pkg::StepsW-1:0]  steps_q;
	logic                        pa_q, na_q, hm_q;
	logic [15:0]                 res_addr_q, out_addr_q;
	logic                        res_ok_q, out_ok_q;

	// Heap state
	logic [AW-1:0]               heads_q [sfl_pkg::NumClasses];
	logic [sfl_pkg::EndW-1:0]    heap_end_q;
	logic [sfl_pkg::WordAw-1:0]  clr_q;

	// Memory port
	logic                        mem_we;
	logic [AW-1:0]               mem_a;
	logic [DW-1:0]               mem_wd, rdata;
	logic [sfl_pkg::WordAw-1:0]  mem_word;

	// Derived values
	logic [DW-1:0]               rsz, pb_c, sum_c;
	logic [AW-1:0]               bp16, head_rd;
	logic [sfl_pkg::ClsW-1:0]    hidx;
	logic [sfl_pkg::AsW-1:0]     asize_c, gext_c;
	logic [sfl_pkg::GsW-1:0]     gs_c;
	logic [sfl_pkg::GsW:0]       gsum;
	logic [sfl_pkg::GsW-3:0]     gw;

	function automatic logic request_size_le16(input logic [15:0] r);
		return r <= 16'd16;
	endfunction

	assign rsz   = sfl_pkg::tsize(rdata);
	assign bp16  = bp_q[AW-1:0];
	assign pb_c  = bp_q - rsz;
	assign sum_c = size_q + ps_q + ns_q;
	assign hidx  = (cmd.step == sfl_pkg::S_F1) ? cls_q : lc_q;
	assign head_rd = heads_q[hidx];

	// Block size from request
	always_comb begin
		if (request_size_le16(req_q))
			asize_c = sfl_pkg::AsW'(sfl_pkg::MinBlock);
		else
			asize_c = (sfl_pkg::AsW'(req_q) + sfl_pkg::AsW'(15)) & ~sfl_pkg::AsW'(7);
		gext_c = (asize_c > sfl_pkg::AsW'(sfl_pkg::ChunkBytes)) ? asize_c
			: sfl_pkg::AsW'(sfl_pkg::ChunkBytes);
	end

	// Growth size rounded up to an even word count
	assign gw    = gext_q[sfl_pkg::AsW-1:2] + (sfl_pkg::GsW-2)'(gext_q[2]);
	assign gs_c  = {gw, 2'b00};
	assign gsum  = (sfl_pkg::GsW+1)'(heap_end_q) + (sfl_pkg::GsW+1)'(gs_c);

	// Status
	always_comb begin
		sts.op       = op_q;
		sts.req_zero = req_q == 16'd0;
		sts.free_bad = (addr_q < 16'(sfl_pkg::FirstBp))
			|| ({1'b0, addr_q} >= heap_end_q) || (addr_q[2:0] != 3'd0);
		sts.rd_alloc = rdata[0];
		sts.clr_last = clr_q == sfl_pkg::WordAw'(sfl_pkg::NWords - 1);
		sts.list_end = (cur_q == '0)
			|| (steps_q == sfl_pkg::StepsW'(sfl_pkg::WalkLimit));
		sts.last_cls = cls_q == sfl_pkg::ClsW'(sfl_pkg::NumClasses - 1);
		sts.fit      = !rdata[0] && (DW'(asize_q) <= rsz);
		sts.gfail    = (gs_c == '0) || (gsum > (sfl_pkg::GsW+1)'(sfl_pkg::HeapLimit));
		sts.bp_zero  = bp_q == '0;
		sts.pa       = pa_q;
		sts.na       = na_q;
		sts.split    = rsz >= (DW'(asize_q) + DW'(sfl_pkg::MinBlock));
	end

	// Memory access of each step
	always_comb begin
		mem_we = 1'b0;
		mem_a  = '0;
		mem_wd = '0;
		case (cmd.step)
			sfl_pkg::S_CLR: mem_we = 1'b1;
			sfl_pkg::S_I0: begin
				mem_we = 1'b1;
				mem_a  = AW'(sfl_pkg::TableArea + 4);
				mem_wd = DW'(9);
			end
			sfl_pkg::S_I1: begin
				mem_we = 1'b1;
				mem_a  = AW'(sfl_pkg::TableArea + 8);
				mem_wd = DW'(9);
			end
			sfl_pkg::S_I2: begin
				mem_we = 1'b1;
				mem_a  = AW'(sfl_pkg::TableArea + 12);
				mem_wd = DW'(1);
			end
			sfl_pkg::S_FR0: mem_a = addr_q - 16'd4;
			sfl_pkg::S_FR1: begin
				mem_we = rdata[0];
				mem_a  = addr_q - 16'd4;
				mem_wd = rsz;
			end
			sfl_pkg::S_FR2: begin
				mem_we = 1'b1;
				mem_a  = addr_q + size_q[AW-1:0] - 16'd8;
				mem_wd = size_q;
			end
			sfl_pkg::S_F2: mem_a = cur_q - 16'd4;
			sfl_pkg::S_F3: mem_a = cur_q + 16'd8;
			sfl_pkg::S_G0: begin
				mem_we = !sts.gfail;
				mem_a  = heap_end_q[AW-1:0] - 16'd4;
				mem_wd = DW'(gs_c);
			end
			sfl_pkg::S_G1: begin
				mem_we = 1'b1;
				mem_a  = bp16 + gs_q[AW-1:0] - 16'd8;
				mem_wd = DW'(gs_q);
			end
			sfl_pkg::S_G2: begin
				mem_we = 1'b1;
				mem_a  = bp16 + gs_q[AW-1:0] - 16'd4;
				mem_wd = DW'(1);
			end
			sfl_pkg::S_M0: mem_a = bp16 - 16'd8;
			sfl_pkg::S_M1: mem_a = pb_c[AW-1:0] - 16'd4;
			sfl_pkg::S_M2: mem_a = pb_q[AW-1:0] + rsz[AW-1:0] - 16'd8;
			sfl_pkg::S_M3: mem_a = bp16 - 16'd4;
			sfl_pkg::S_M4: mem_a = bp16 + rsz[AW-1:0] - 16'd4;
			sfl_pkg::S_MA1: begin
				mem_we = 1'b1;
				mem_a  = bp16 - 16'd4;
				mem_wd = size_q + ns_q;
			end
			sfl_pkg::S_MA2: begin
				mem_we = 1'b1;
				mem_a  = bp16 + size_q[AW-1:0] - 16'd8;
				mem_wd = size_q;
			end
			sfl_pkg::S_MB1: begin
				mem_we = 1'b1;
				mem_a  = bp16 + size_q[AW-1:0] - 16'd8;
				mem_wd = size_q + ps_q;
			end
			sfl_pkg::S_MB2: begin
				mem_we = 1'b1;
				mem_a  = pb_q[AW-1:0] - 16'd4;
				mem_wd = size_q;
			end
			sfl_pkg::S_MC2: begin
				mem_we = 1'b1;
				mem_a  = pb_q[AW-1:0] - 16'd4;
				mem_wd = sum_c;
			end
			sfl_pkg::S_MC3: begin
				mem_we = 1'b1;
				mem_a  = nb_q + ns_q[AW-1:0] - 16'd8;
				mem_wd = size_q;
			end
			sfl_pkg::S_P0: mem_a = bp16 - 16'd4;
			sfl_pkg::S_PS0: begin
				mem_we = 1'b1;
				mem_a  = bp16 - 16'd4;
				mem_wd = DW'(asize_q) | DW'(1);
			end
			sfl_pkg::S_PS1: begin
				mem_we = 1'b1;
				mem_a  = bp16 + asize_q[AW-1:0] - 16'd8;
				mem_wd = DW'(asize_q) | DW'(1);
			end
			sfl_pkg::S_PS2: begin
				mem_we = 1'b1;
				mem_a  = bp16 + asize_q[AW-1:0] - 16'd4;
				mem_wd = csize_q - DW'(asize_q);
			end
			sfl_pkg::S_PS3: begin
				mem_we = 1'b1;
				mem_a  = bp16 + csize_q[AW-1:0] - 16'd8;
				mem_wd = csize_q - DW'(asize_q);
			end
			sfl_pkg::S_PN0: begin
				mem_we = 1'b1;
				mem_a  = bp16 - 16'd4;
				mem_wd = csize_q | DW'(1);
			end
			sfl_pkg::S_PN1: begin
				mem_we = 1'b1;
				mem_a  = bp16 + csize_q[AW-1:0] - 16'd8;
				mem_wd = csize_q | DW'(1);
			end
			sfl_pkg::S_RM0: mem_a = lx_q;
			sfl_pkg::S_RM1: mem_a = lx_q + 16'd8;
			sfl_pkg::S_RM3: begin
				mem_we = hm_q && (ln_q != '0);
				mem_a  = ln_q;
			end
			sfl_pkg::S_RM4: begin
				mem_we = !(hm_q && (ln_q == '0)) && (lp_q != '0);
				mem_a  = lp_q + 16'd8;
				mem_wd = DW'(ln_q);
			end
			sfl_pkg::S_RM5: begin
				mem_we = ln_q != '0;
				mem_a  = ln_q;
				mem_wd = DW'(lp_q);
			end
			sfl_pkg::S_IN0: begin
				mem_we = head_rd != '0;
				mem_a  = head_rd;
				mem_wd = DW'(lx_q);
			end
			sfl_pkg::S_IN1: begin
				mem_we = 1'b1;
				mem_a  = lx_q;
			end
			sfl_pkg::S_IN2: begin
				mem_we = 1'b1;
				mem_a  = lx_q + 16'd8;
				mem_wd = DW'(head_rd);
			end
			default: mem_we = 1'b0;
		endcase
	end

	assign mem_word = (cmd.step == sfl_pkg::S_CLR) ? clr_q
		: mem_a[sfl_pkg::WordAw+1:2];

	sfl_ram #(
		.Width (DW),
		.Depth (sfl_pkg::NWords)
	) u_heap (
		.clk   (clk),
		.we    (mem_we),
		.addr  (mem_word),
		.wdata (mem_wd),
		.rdata (rdata)
	);

	// Class heads, heap end and clear counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < sfl_pkg::NumClasses; i++)
				heads_q[i] <= '0;
			heap_end_q <= '0;
			clr_q      <= '0;
		end else begin
			case (cmd.step)
				sfl_pkg::S_CLR: clr_q <= clr_q + 1'b1;
				sfl_pkg::S_I2:  heap_end_q <= sfl_pkg::EndW'(sfl_pkg::FirstBp);
				sfl_pkg::S_G2:  heap_end_q <= heap_end_q + sfl_pkg::EndW'(gs_q);
				sfl_pkg::S_RM2: begin
					if (heads_q[lc_q] == lx_q)
						heads_q[lc_q] <= rdata[AW-1:0];
				end
				sfl_pkg::S_IN2: heads_q[lc_q] <= lx_q;
				default: clr_q <= clr_q;
			endcase
		end
	end

	// Working registers
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q   <= op;
			req_q  <= request_size;
			addr_q <= block_addr;
		end
		if (cmd.load_out) begin
			out_addr_q <= res_addr_q;
			out_ok_q   <= res_ok_q;
		end
		case (cmd.step)
			sfl_pkg::S_I2: gext_q <= sfl_pkg::AsW'(sfl_pkg::ChunkBytes);
			sfl_pkg::S_DSP: begin
				asize_q    <= asize_c;
				cls_q      <= sfl_pkg::class_of(DW'(asize_c));
				gext_q     <= gext_c;
				res_addr_q <= '0;
				res_ok_q   <= op_q;
			end
			sfl_pkg::S_FR1: size_q <= rsz;
			sfl_pkg::S_FR2: bp_q <= DW'(addr_q);
			sfl_pkg::S_F1: begin
				cur_q   <= head_rd;
				steps_q <= '0;
			end
			sfl_pkg::S_F2: begin
				if (sts.list_end && !sts.last_cls)
					cls_q <= cls_q + 1'b1;
			end
			sfl_pkg::S_F3: begin
				if (sts.fit)
					bp_q <= DW'(cur_q);
			end
			sfl_pkg::S_F4: begin
				cur_q   <= rdata[AW-1:0];
				steps_q <= steps_q + 1'b1;
			end
			sfl_pkg::S_G0: begin
				bp_q <= DW'(heap_end_q);
				gs_q <= gs_c;
			end
			sfl_pkg::S_M1: pb_q <= pb_c;
			sfl_pkg::S_M2: ps_q <= rsz;
			sfl_pkg::S_M3: pa_q <= rdata[0];
			sfl_pkg::S_M4: begin
				size_q <= rsz;
				nb_q   <= bp16 + rsz[AW-1:0];
			end
			sfl_pkg::S_M5: begin
				na_q <= rdata[0];
				ns_q <= rsz;
			end
			sfl_pkg::S_M6: begin
				if (pa_q && na_q) begin
					lc_q <= sfl_pkg::class_of(size_q);
					lx_q <= bp16;
				end else if (pa_q) begin
					lc_q <= sfl_pkg::class_of(ns_q);
					lx_q <= nb_q;
				end else begin
					lc_q <= sfl_pkg::class_of(ps_q);
					lx_q <= pb_q[AW-1:0];
				end
			end
			sfl_pkg::S_MA1: size_q <= size_q + ns_q;
			sfl_pkg::S_MA2: begin
				lc_q <= sfl_pkg::class_of(size_q);
				lx_q <= bp16;
			end
			sfl_pkg::S_MB1: size_q <= size_q + ps_q;
			sfl_pkg::S_MB2, sfl_pkg::S_MC3: begin
				bp_q <= pb_q;
				lc_q <= sfl_pkg::class_of(size_q);
				lx_q <= pb_q[AW-1:0];
			end
			sfl_pkg::S_MC1: begin
				lc_q <= sfl_pkg::class_of(ns_q);
				lx_q <= nb_q;
			end
			sfl_pkg::S_MC2: size_q <= sum_c;
			sfl_pkg::S_P0: begin
				res_addr_q <= bp16;
				res_ok_q   <= 1'b1;
			end
			sfl_pkg::S_P1: begin
				csize_q <= rsz;
				pc_q    <= sfl_pkg::class_of(rsz);
			end
			sfl_pkg::S_PS1, sfl_pkg::S_PN1: begin
				lc_q <= pc_q;
				lx_q <= bp16;
			end
			sfl_pkg::S_PS3: begin
				lc_q <= sfl_pkg::class_of(csize_q - DW'(asize_q));
				lx_q <= bp16 + asize_q[AW-1:0];
			end
			sfl_pkg::S_RM1: lp_q <= rdata[AW-1:0];
			sfl_pkg::S_RM2: begin
				ln_q <= rdata[AW-1:0];
				hm_q <= heads_q[lc_q] == lx_q;
			end
			default: pa_q <= pa_q;
		endcase
	end

	assign result_addr = out_addr_q;
	assign ok          = out_ok_q;

endmodule

/* design/sfl_ctrl.sv */
module sfl_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	output logic          out_valid,
	input  logic          out_stall,
	output sfl_pkg::cmd_t cmd,
	input  sfl_pkg::sts_t sts
);

	logic [sfl_pkg::StW-1:0] state_q, state_d;
	logic [sfl_pkg::StW-1:0] lret_q, lret_d;
	logic [sfl_pkg::StW-1:0] mret_q, mret_d;
	logic                    init_q;
	logic                    out_valid_q;

	assign in_stall     = state_q != sfl_pkg::S_IDLE;
	assign out_valid    = out_valid_q;
	assign cmd.step     = state_q;
	assign cmd.accept   = (state_q == sfl_pkg::S_IDLE) && in_valid;
	assign cmd.load_out = (state_q == sfl_pkg::S_DONE) && (!out_valid_q || !out_stall);

	// Step sequencing
	always_comb begin
		state_d = state_q;
		lret_d  = lret_q;
		mret_d  = mret_q;
		case (state_q)
			sfl_pkg::S_CLR:  if (sts.clr_last) state_d = sfl_pkg::S_I0;
			sfl_pkg::S_I0:   state_d = sfl_pkg::S_I1;
			sfl_pkg::S_I1:   state_d = sfl_pkg::S_I2;
			sfl_pkg::S_I2:   state_d = sfl_pkg::S_G0;
			sfl_pkg::S_IDLE: if (in_valid) state_d = sfl_pkg::S_DSP;
			sfl_pkg::S_DSP: begin
				if (!sts.op)
					state_d = sts.req_zero ? sfl_pkg::S_DONE : sfl_pkg::S_F1;
				else
					state_d = sts.free_bad ? sfl_pkg::S_DONE : sfl_pkg::S_FR0;
			end
			sfl_pkg::S_DONE: if (cmd.load_out) state_d = sfl_pkg::S_IDLE;
			// Free
			sfl_pkg::S_FR0:  state_d = sfl_pkg::S_FR1;
			sfl_pkg::S_FR1:  state_d = sts.rd_alloc ? sfl_pkg::S_FR2 : sfl_pkg::S_DONE;
			sfl_pkg::S_FR2: begin
				state_d = sfl_pkg::S_M0;
				mret_d  = sfl_pkg::S_DONE;
			end
			// First-fit walk
			sfl_pkg::S_F1:   state_d = sfl_pkg::S_F2;
			sfl_pkg::S_F2: begin
				if (!sts.list_end)
					state_d = sfl_pkg::S_F3;
				else
					state_d = sts.last_cls ? sfl_pkg::S_G0 : sfl_pkg::S_F1;
			end
			sfl_pkg::S_F3:   state_d = sts.fit ? sfl_pkg::S_P0 : sfl_pkg::S_F4;
			sfl_pkg::S_F4:   state_d = sfl_pkg::S_F2;
			// Heap growth
			sfl_pkg::S_G0: begin
				if (sts.gfail) begin
					state_d = init_q ? sfl_pkg::S_IDLE : sfl_pkg::S_DONE;
				end else begin
					state_d = sfl_pkg::S_G1;
					mret_d  = init_q ? sfl_pkg::S_IDLE : sfl_pkg::S_GR;
				end
			end
			sfl_pkg::S_G1:   state_d = sfl_pkg::S_G2;
			sfl_pkg::S_G2:   state_d = sfl_pkg::S_M0;
			sfl_pkg::S_GR:   state_d = sts.bp_zero ? sfl_pkg::S_DONE : sfl_pkg::S_P0;
			// Coalescing
			sfl_pkg::S_M0:   state_d = sfl_pkg::S_M1;
			sfl_pkg::S_M1:   state_d = sfl_pkg::S_M2;
			sfl_pkg::S_M2:   state_d = sfl_pkg::S_M3;
			sfl_pkg::S_M3:   state_d = sfl_pkg::S_M4;
			sfl_pkg::S_M4:   state_d = sfl_pkg::S_M5;
			sfl_pkg::S_M5:   state_d = sfl_pkg::S_M6;
			sfl_pkg::S_M6: begin
				if (sts.pa && sts.na) begin
					state_d = sfl_pkg::S_IN0;
					lret_d  = mret_q;
				end else begin
					state_d = sfl_pkg::S_RM0;
					if (sts.pa)
						lret_d = sfl_pkg::S_MA1;
					else if (sts.na)
						lret_d = sfl_pkg::S_MB1;
					else
						lret_d = sfl_pkg::S_MC1;
				end
			end
			sfl_pkg::S_MA1:  state_d = sfl_pkg::S_MA2;
			sfl_pkg::S_MB1:  state_d = sfl_pkg::S_MB2;
			sfl_pkg::S_MA2, sfl_pkg::S_MB2, sfl_pkg::S_MC3: begin
				state_d = sfl_pkg::S_IN0;
				lret_d  = mret_q;
			end
			sfl_pkg::S_MC1: begin
				state_d = sfl_pkg::S_RM0;
				lret_d  = sfl_pkg::S_MC2;
			end
			sfl_pkg::S_MC2:  state_d = sfl_pkg::S_MC3;
			// Placement
			sfl_pkg::S_P0:   state_d = sfl_pkg::S_P1;
			sfl_pkg::S_P1:   state_d = sts.split ? sfl_pkg::S_PS0 : sfl_pkg::S_PN0;
			sfl_pkg::S_PS0:  state_d = sfl_pkg::S_PS1;
			sfl_pkg::S_PS1: begin
				state_d = sfl_pkg::S_RM0;
				lret_d  = sfl_pkg::S_PS2;
			end
			sfl_pkg::S_PS2:  state_d = sfl_pkg::S_PS3;
			sfl_pkg::S_PS3: begin
				state_d = sfl_pkg::S_IN0;
				lret_d  = sfl_pkg::S_DONE;
			end
			sfl_pkg::S_PN0:  state_d = sfl_pkg::S_PN1;
			sfl_pkg::S_PN1: begin
				state_d = sfl_pkg::S_RM0;
				lret_d  = sfl_pkg::S_DONE;
			end
			// List unlink and insert
			sfl_pkg::S_RM0:  state_d = sfl_pkg::S_RM1;
			sfl_pkg::S_RM1:  state_d = sfl_pkg::S_RM2;
			sfl_pkg::S_RM2:  state_d = sfl_pkg::S_RM3;
			sfl_pkg::S_RM3:  state_d = sfl_pkg::S_RM4;
			sfl_pkg::S_RM4:  state_d = sfl_pkg::S_RM5;
			sfl_pkg::S_RM5:  state_d = lret_q;
			sfl_pkg::S_IN0:  state_d = sfl_pkg::S_IN1;
			sfl_pkg::S_IN1:  state_d = sfl_pkg::S_IN2;
			sfl_pkg::S_IN2:  state_d = lret_q;
			default:         state_d = sfl_pkg::S_IDLE;
		endcase
	end

	// State and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sfl_pkg::S_CLR;
			lret_q      <= sfl_pkg::S_IDLE;
			mret_q      <= sfl_pkg::S_IDLE;
			init_q      <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			lret_q  <= lret_d;
			mret_q  <= mret_d;
			if (state_q == sfl_pkg::S_IDLE)
				init_q <= 1'b0;
			if (cmd.load_out)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	// Result loaded only into a free or draining output slot
	a_load_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || !out_stall))
		else $error("result overwrote a held transaction");

	// An accepted transaction goes straight to dispatch
	a_accept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |=> (state_q == sfl_pkg::S_DSP))
		else $error("accepted transaction not dispatched");

	// List unlink returns to its caller
	a_ret: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sfl_pkg::S_RM5) |=> (state_q == $past(lret_q)))
		else $error("list unlink lost its return step");

	// No transaction taken before the heap is laid out
	a_init: assert property (@(posedge clk) disable iff (!arst_n)
		init_q && (state_q != sfl_pkg::S_IDLE) |-> in_stall)
		else $error("transaction taken during initialisation");

endmodule

/* design/segregated_free_list_allocator_unit.sv */
// A zero-size request or an out-of-range free goes straight to the result, a free of a
// block not marked allocated ends once its header is read, and the first-fit walk adds
// steps for each free block visited; every step is one access to the single-port heap memory.
// Throughput: one transaction at a time; the next is taken once the result is registered.
// Reset: a clearing pass zeroes all 16384 words of the heap, then the prologue, epilogue
// and a 512-byte free chunk are laid before the first transaction.
module segregated_free_list_allocator_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        op,
	input  logic [15:0] request_size,
	input  logic [15:0] block_addr,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] result_addr,
	output logic        ok
);

	sfl_pkg::cmd_t cmd;
	sfl_pkg::sts_t sts;

	sfl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	sfl_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.op           (op),
		.request_size (request_size),
		.block_addr   (block_addr),
		.result_addr  (result_addr),
		.ok           (ok)
	);

endmodule

/* sim/segregated_free_list_allocator_unit_tb.sv */
module segregated_free_list_allocator_unit_tb;

	localparam int HeapW     = sfl_pkg::NWords;
	localparam int StallLim  = 40000;
	localparam int WalkSteps = sfl_pkg::HeapLimit / 8;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic        op;
	logic [15:0] request_size;
	logic [15:0] block_addr;
	logic        out_valid;
	logic        out_stall;
	logic [15:0] result_addr;
	logic        ok;

	typedef enum logic {OP_ALLOC = 1'b0, OP_FREE = 1'b1} op_e;

	typedef struct packed {
		logic [15:0] addr;
		logic        ok;
	} alloc_res_t;

	// Shadow heap: words, class heads, end of heap
	logic [31:0] shadow_mem [HeapW];
	logic [15:0] shadow_head [sfl_pkg::NumClasses];
	logic [31:0] shadow_end;

	// Addresses of blocks currently held, for well-formed frees
	logic [15:0] held_blocks [$];

	// Tally for the summary
	int n_alloc, n_free, n_fail;

	segregated_free_list_allocator_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.op           (op),
		.request_size (request_size),
		.block_addr   (block_addr),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.result_addr  (result_addr),
		.ok           (ok)
	);

	// Scoreboard of expected allocator results
	class alloc_scoreboard;
		alloc_res_t pending [$];
		int         errors;

		function void note(alloc_res_t r);
			pending.push_back(r);
		endfunction

		function void check(logic [15:0] a, logic k);
			alloc_res_t e;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result addr=%h ok=%b", $time, a, k);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (e.addr !== a) begin
				$display("%0t: result_addr expected %h actual %h", $time, e.addr, a);
				errors++;
			end
			if (e.ok !== k) begin
				$display("%0t: ok expected %b actual %b", $time, e.ok, k);
				errors++;
			end
		endfunction
	endclass

	alloc_scoreboard sb;

	// ---- heap shadow accessors ----
	function automatic logic [31:0] mrd(logic [31:0] a);
		return shadow_mem[(a >> 2) % HeapW];
	endfunction

	function automatic void mwr(logic [31:0] a, logic [31:0] v);
		shadow_mem[(a >> 2) % HeapW] = v;
	endfunction

	function automatic logic [31:0] tag_size(logic [31:0] a);
		return mrd(a) & ~32'd7;
	endfunction

	function automatic logic tag_used(logic [31:0] a);
		logic [31:0] v;
		v = mrd(a);
		return v[0];
	endfunction

	function automatic int size_class(logic [31:0] s);
		int c;
		c = 0;
		while (c < sfl_pkg::NumClasses - 1 && s >= (32'd32 << c))
			c++;
		return c;
	endfunction

	function automatic void link_push(int c, logic [31:0] bp);
		logic [31:0] root;
		root = shadow_head[c];
		if (root != 0)
			mwr(root, root == 0 ? 0 : {16'd0, bp[15:0]});
		mwr(bp, 0);
		mwr(bp + 8, {16'd0, root[15:0]});
		shadow_head[c] = bp[15:0];
	endfunction

	function automatic void link_drop(int c, logic [31:0] bp);
		logic [31:0] p, n;
		p = mrd(bp) & 32'hFFFF;
		n = mrd(bp + 8) & 32'hFFFF;
		if (shadow_head[c] == bp[15:0]) begin
			shadow_head[c] = n[15:0];
			if (n == 0)
				return;
			mwr(n, 0);
		end
		if (p != 0)
			mwr(p + 8, n);
		if (n != 0)
			mwr(n, p);
	endfunction

	function automatic logic [31:0] coalesce(logic [31:0] bp);
		logic [31:0] pb, nb, sz, ps, ns;
		logic        pa, na;
		pb = bp - tag_size(bp - 8);
		nb = bp + tag_size(bp - 4);
		pa = tag_used(pb + tag_size(pb - 4) - 8);
		na = tag_used(nb - 4);
		sz = tag_size(bp - 4);
		if (pa && na) begin
		end else if (pa) begin
			ns = tag_size(nb - 4);
			link_drop(size_class(ns), nb);
			sz += ns;
			mwr(bp - 4, sz);
			mwr(bp + sz - 8, sz);
		end else if (na) begin
			ps = tag_size(pb - 4);
			link_drop(size_class(ps), pb);
			mwr(bp + sz - 8, sz + ps);
			sz += ps;
			mwr(pb - 4, sz);
			bp = pb;
		end else begin
			ps = tag_size(pb - 4);
			ns = tag_size(nb - 4);
			link_drop(size_class(ps), pb);
			link_drop(size_class(ns), nb);
			sz += ps + ns;
			mwr(pb - 4, sz);
			mwr(nb + ns - 8, sz);
			bp = pb;
		end
		link_push(size_class(sz), bp);
		return bp;
	endfunction

	function automatic logic [31:0] grow_shadow(logic [31:0] bytes);
		logic [31:0] w, sz, bp;
		w = bytes / 4;
		if (w[0])
			w++;
		sz = w * 4;
		if (sz == 0 || shadow_end + sz > sfl_pkg::HeapLimit)
			return 0;
		bp = shadow_end;
		mwr(bp - 4, sz);
		mwr(bp + sz - 8, sz);
		mwr(bp + sz - 4, 1);
		shadow_end += sz;
		return coalesce(bp);
	endfunction

	function automatic logic [31:0] first_fit(logic [31:0] asz);
		logic [31:0] bp;
		int          steps;
		for (int c = size_class(asz); c < sfl_pkg::NumClasses; c++) begin
			bp = shadow_head[c];
			steps = 0;
			while (bp != 0 && steps < WalkSteps) begin
				if (!tag_used(bp - 4) && asz <= tag_size(bp - 4))
					return bp;
				bp = mrd(bp + 8) & 32'hFFFF;
				steps++;
			end
		end
		return 0;
	endfunction

	function automatic void carve(logic [31:0] bp, logic [31:0] asz);
		logic [31:0] cs, sb, ss;
		int          c;
		cs = tag_size(bp - 4);
		c = size_class(cs);
		if (cs >= asz + sfl_pkg::MinBlock) begin
			sb = bp + asz;
			ss = cs - asz;
			mwr(bp - 4, asz | 1);
			mwr(bp + asz - 8, asz | 1);
			link_drop(c, bp);
			mwr(sb - 4, ss);
			mwr(sb + ss - 8, ss);
			link_push(size_class(ss), sb);
		end else begin
			mwr(bp - 4, cs | 1);
			mwr(bp + cs - 8, cs | 1);
			link_drop(c, bp);
		end
	endfunction

	function automatic void heap_init();
		logic [31:0] dummy;
		foreach (shadow_mem[i])
			shadow_mem[i] = 0;
		foreach (shadow_head[i])
			shadow_head[i] = 0;
		mwr(sfl_pkg::TableArea + 4, 9);
		mwr(sfl_pkg::TableArea + 8, 9);
		mwr(sfl_pkg::TableArea + 12, 1);
		shadow_end = sfl_pkg::FirstBp;
		dummy = grow_shadow(sfl_pkg::ChunkBytes);
	endfunction

	// Predicts the result of one request and updates the shadow heap
	function automatic alloc_res_t predict_alloc(logic o, logic [15:0] req, logic [15:0] ba);
		alloc_res_t  r;
		logic [31:0] asz, bp, sz, a;
		r.addr = 0;
		r.ok = 1;
		a = {16'd0, ba};
		if (o == OP_ALLOC) begin
			if (req == 0) begin
				r.ok = 0;
				return r;
			end
			asz = (req <= 16) ? sfl_pkg::MinBlock : 8 * ((32'(req) + 15) / 8);
			bp = first_fit(asz);
			if (bp == 0)
				bp = grow_shadow(asz > sfl_pkg::ChunkBytes ? asz : sfl_pkg::ChunkBytes);
			if (bp == 0) begin
				r.ok = 0;
				return r;
			end
			carve(bp, asz);
			r.addr = bp[15:0];
		end else begin
			if (a < sfl_pkg::FirstBp || a >= shadow_end || a[2:0] != 0)
				return r;
			if (!tag_used(a - 4))
				return r;
			sz = tag_size(a - 4);
			mwr(a - 4, sz);
			mwr(a + sz - 8, sz);
			void'(coalesce(a));
		end
		return r;
	endfunction

	// ---- clock and reset ----
	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	// ---- sender ----
	int  idle_in;     // 0 = random gaps, 1 = no gaps
	bit  stim_done;
	int  watchdog;
	bit  hold_rx;     // long receiver hold-off, cleared by the receiver
	bit  calm_rx;

	task automatic send_req(logic o, logic [15:0] req, logic [15:0] ba);
		alloc_res_t r;
		int gap;
		if (!idle_in && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 8);
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1;
		op <= o;
		request_size <= req;
		block_addr <= ba;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		// accepted at this edge
		r = predict_alloc(o, req, ba);
		sb.note(r);
		if (o == OP_ALLOC) begin
			n_alloc++;
			if (r.ok)
				held_blocks.push_back(r.addr);
			else
				n_fail++;
		end else begin
			n_free++;
		end
	endtask

	task automatic wait_drain();
		in_valid <= 0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	function automatic logic [15:0] pick_size();
		int k;
		k = $urandom_range(0, 19);
		if (k < 12)
			return 16'($urandom_range(1, 64));
		else if (k < 17)
			return 16'($urandom_range(65, 1024));
		else if (k < 19)
			return 16'($urandom_range(1025, 4096));
		return 16'($urandom);
	endfunction

	task automatic do_free_held();
		int          i;
		logic [15:0] a;
		i = $urandom_range(0, held_blocks.size() - 1);
		a = held_blocks[i];
		held_blocks.delete(i);
		send_req(OP_FREE, 0, a);
	endtask

	task automatic random_item();
		int k;
		k = $urandom_range(0, 99);
		if (k < 50 || held_blocks.size() == 0)
			send_req(OP_ALLOC, pick_size(), 16'($urandom));
		else if (k < 90)
			do_free_held();
		else if (k < 94)
			send_req(OP_FREE, 16'($urandom), 16'($urandom));
		else if (k < 97)
			send_req(OP_FREE, 16'($urandom),
				16'(sfl_pkg::FirstBp + 8 * $urandom_range(0, 40)));
		else
			send_req(OP_ALLOC, 0, 16'($urandom));
	endtask

	initial begin
		sb = new();
		arst_n = 0;
		in_valid = 0;
		op = OP_ALLOC;
		request_size = 0;
		block_addr = 0;
		idle_in = 0;
		stim_done = 0;
		hold_rx = 0;
		calm_rx = 0;
		heap_init();
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: extremes, zero size, null and bad frees, heap exhaustion
		send_req(OP_ALLOC, 0, 16'hFFFF);
		send_req(OP_ALLOC, 1, 0);
		send_req(OP_ALLOC, 16, 0);
		send_req(OP_ALLOC, 17, 0);
		send_req(OP_ALLOC, 500, 0);
		send_req(OP_ALLOC, 4000, 0);
		send_req(OP_FREE, 16'hFFFF, 0);
		send_req(OP_FREE, 0, 16'h0060);
		send_req(OP_FREE, 0, 16'h006C);
		send_req(OP_FREE, 0, 16'hFFF8);
		send_req(OP_FREE, 0, 16'hFFFF);
		send_req(OP_ALLOC, 16'hFFFF, 16'hFFFF);
		send_req(OP_ALLOC, 16'd40000, 0);
		send_req(OP_ALLOC, 16'd30000, 0);
		send_req(OP_FREE, 0, held_blocks[1]);
		send_req(OP_FREE, 0, held_blocks[1]);
		held_blocks.delete(1);
		while (held_blocks.size() > 0)
			do_free_held();
		send_req(OP_ALLOC, 24, 16'h5555);
		send_req(OP_ALLOC, 16'hAAAA, 16'hAAAA);

		// Random with hold-off: receiver blocks while sender keeps offering
		hold_rx = 1;
		repeat (30) random_item();
		repeat (400) random_item();

		// Sender pause until all results are back
		wait_drain();
		repeat (400) random_item();

		// Last part: no idling either side
		idle_in = 1;
		calm_rx = 1;
		repeat (250) random_item();
		in_valid <= 0;
		stim_done = 1;
	end

	// ---- receiver ----
	initial begin
		int gap;
		out_stall = 1;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_rx) begin
				out_stall <= 1;
				repeat (600) @(posedge clk);
				hold_rx = 0;
				out_stall <= 0;
			end else if (!calm_rx && $urandom_range(0, 7) == 0) begin
				gap = $urandom_range(1, 8);
				out_stall <= 1;
				repeat (gap - 1) @(posedge clk);
			end else begin
				out_stall <= 0;
			end
		end
	end

	// Result check at each accepted output
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check(result_addr, ok);
	end

	// Watchdog on cycles with no transaction; the reset clearing pass is allowed for
	initial begin
		watchdog = 0;
		forever begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				watchdog = 0;
			else
				watchdog++;
			if (watchdog > StallLim) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	// End of run
	initial begin
		wait (stim_done);
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		$display("Run: %0d allocations (%0d failed), %0d frees, heap end 0x%0h",
			n_alloc, n_fail, n_free, shadow_end);
		$display("Covered zero sizes, null and bad frees, heap growth and exhaustion.");
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

/* filelist.f */
design/sfl_pkg.sv
design/sfl_ram.sv
design/sfl_dp.sv
design/sfl_ctrl.sv
design/segregated_free_list_allocator_unit.sv
sim/segregated_free_list_allocator_unit_tb.sv
